FILE: rtl/core/nrhp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Nearest ray hit picker package
// Widths, reset values, codes and the cross magnitude helper shared by the
// channel interfaces and the picker.
// ----------------------------------------------------------------------------
package nrhp_pkg;

  // Largest number of entities tested in one query; further entities are
  // counted out but not tested.
  localparam int unsigned MAX_ENTITIES = 1024;
  localparam int unsigned IDX_W        = $clog2(MAX_ENTITIES);
  localparam int unsigned CNT_W        = $clog2(MAX_ENTITIES + 1);

  // Fixed field widths.
  localparam int unsigned CRD_W      = 24;  // Q12.12 coordinate
  localparam int unsigned C_W        = 25;  // camera minus entity
  localparam int unsigned OP_W       = 26;  // multiplier operand
  localparam int unsigned PROD_W     = 52;  // multiplier product
  localparam int unsigned DOT_W      = 50;  // dot product sum
  localparam int unsigned CR_W       = 50;  // one cross component
  localparam int unsigned M_W        = 25;  // reduced cross magnitude
  localparam int unsigned XSQ_W      = 52;  // squared cross sum
  localparam int unsigned DIST_W     = 50;  // squared distance
  localparam int unsigned LIM_W      = 50;  // squared hit limit
  localparam int unsigned FRAC_W     = 12;  // fraction bits of Q12.12
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 50;

  localparam logic [CRD_W-1:0] DIR_Z_RST = 24'hFFF000;  // -1.0
  localparam logic [LIM_W-1:0] LIMIT_RST = 50'd4194304; // 0.25

  localparam logic MODE_RAY    = 1'b0;
  localparam logic MODE_ENTITY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAM_POS_X,
    REG_CAM_POS_Y,
    REG_CAM_POS_Z,
    REG_CAM_DIR_X,
    REG_CAM_DIR_Y,
    REG_CAM_DIR_Z,
    REG_HIT_LIMIT
  } nrhp_reg_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_RUN,
    FSM_FINISH
  } nrhp_fsm_e;

  // One step per multiplier product, plus a final step that drains the
  // last product into its accumulator.
  typedef enum logic [3:0] {
    STEP_DX,
    STEP_DY,
    STEP_DZ,
    STEP_QX,
    STEP_QY,
    STEP_QZ,
    STEP_R0A,
    STEP_R0B,
    STEP_R1A,
    STEP_R1B,
    STEP_R2A,
    STEP_R2B,
    STEP_M0,
    STEP_M1,
    STEP_M2,
    STEP_FLUSH
  } nrhp_step_e;

  typedef struct packed {
    logic           big;
    logic [M_W-1:0] mag;
  } nrhp_mag_t;

  // Magnitude of a cross component truncated to 12 fraction bits, with a
  // flag for magnitudes too large to square into the hit test.
  function automatic nrhp_mag_t cross_mag(input logic signed [CR_W-1:0] v);
    logic [CR_W-1:0] abs_v;
    nrhp_mag_t       res;
    abs_v   = v[CR_W-1] ? CR_W'(-v) : CR_W'(v);
    res.big = |abs_v[CR_W-1:FRAC_W+M_W];
    res.mag = abs_v[FRAC_W+M_W-1:FRAC_W];
    return res;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/nrhp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Nearest ray hit picker channels
// Valid/ready interfaces for the input item stream and the result stream.
// ----------------------------------------------------------------------------
interface nrhp_in_if;
  import nrhp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    mode;
  logic signed [CRD_W-1:0] vec_x;
  logic signed [CRD_W-1:0] vec_y;
  logic signed [CRD_W-1:0] vec_z;
  logic                    alive;
  logic                    last;

  modport source (output valid, mode, vec_x, vec_y, vec_z, alive, last, input ready);
  modport sink   (input valid, mode, vec_x, vec_y, vec_z, alive, last, output ready);
endinterface

interface nrhp_out_if;
  import nrhp_pkg::*;

  logic              valid;
  logic              ready;
  logic              found;
  logic [IDX_W-1:0]  best_index;
  logic [DIST_W-1:0] best_dist_sq;

  modport source (output valid, found, best_index, best_dist_sq, input ready);
  modport sink   (input valid, found, best_index, best_dist_sq, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/nearest_ray_hit_picker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Nearest ray hit picker
// Tests point entities against a query ray and returns the nearest hit.
// ----------------------------------------------------------------------------
// A beat with mode 0 loads the query ray and starts a new query. Each beat
// with mode 1 is one entity. A live entity within the entity limit is tested
// by a sequencer that drives one shared 26 x 26 signed multiplier through
// fifteen products (dot product with the camera direction, squared distance,
// the six cross terms and the three squared cross magnitudes), so the input
// is not ready again until the sequencer has walked its sixteen steps and
// the entity has been decided. A dead entity, or one beyond the entity
// limit, skips the sequencer and goes straight to the decision. The entity
// marked last produces one result beat; the result sits in an output register
// and the next item is accepted while it waits, except that a further result
// stalls in the decision cycle until the previous one has been taken. There
// is no clearing pass after reset. Configuration registers may be written at
// any time the block is idle.
// ----------------------------------------------------------------------------
module nearest_ray_hit_picker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [nrhp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [nrhp_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  nrhp_in_if.sink                           in_i,
  nrhp_out_if.source                        out_o
);
  import nrhp_pkg::*;

  // Configuration registers.
  logic signed [CRD_W-1:0] cam_pos_q [3];
  logic signed [CRD_W-1:0] cam_dir_q [3];
  logic [LIM_W-1:0]        limit_q;

  // Query state.
  logic signed [CRD_W-1:0] ray_q [3];
  logic [DIST_W-1:0]       best_dist_q;
  logic [IDX_W-1:0]        best_idx_q;
  logic                    hit_seen_q;
  logic [CNT_W-1:0]        ent_cnt_q;

  // Control.
  nrhp_fsm_e  state_q, state_d;
  nrhp_step_e step_q, step_d;
  nrhp_step_e acc_tag_q;
  logic       acc_en_q;
  logic       test_q;
  logic       last_q;
  logic       finish_go;
  logic       emit;

  // Entity datapath.
  logic signed [C_W-1:0]    c_q [3];
  logic [IDX_W-1:0]         cur_idx_q;
  logic signed [OP_W-1:0]   op_a, op_b;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [DOT_W-1:0]  dot_q;
  logic [DIST_W-1:0]        dist_q;
  logic signed [CR_W-1:0]   cr_q;
  logic [M_W-1:0]           mag_q [3];
  logic                     big_q;
  logic [XSQ_W-1:0]         xsq_q;
  nrhp_mag_t                cm;

  // Result register.
  logic              out_valid_q;
  logic              out_found_q;
  logic [IDX_W-1:0]  out_idx_q;
  logic [DIST_W-1:0] out_dist_q;

  // Decision terms.
  logic              in_acc;
  logic              ent_in_range;
  logic              dot_pos;
  logic              hit;
  logic              better;
  logic              new_seen;
  logic [IDX_W-1:0]  new_idx;
  logic [DIST_W-1:0] new_dist;
  logic              slot_free;

  assign in_i.ready   = (state_q == FSM_IDLE);
  assign in_acc       = in_i.valid && in_i.ready;
  assign ent_in_range = (ent_cnt_q < CNT_W'(MAX_ENTITIES));
  assign slot_free    = !out_valid_q || out_o.ready;

  assign out_o.valid        = out_valid_q;
  assign out_o.found        = out_found_q;
  assign out_o.best_index   = out_idx_q;
  assign out_o.best_dist_sq = out_dist_q;

  // --------------------------------------------------------------------------
  // Configuration writes. Index seven is not a register and is ignored.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_pos_q[0] <= '0;
      cam_pos_q[1] <= '0;
      cam_pos_q[2] <= '0;
      cam_dir_q[0] <= '0;
      cam_dir_q[1] <= '0;
      cam_dir_q[2] <= DIR_Z_RST;
      limit_q      <= LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (nrhp_reg_e'(cfg_idx_i))
        REG_CAM_POS_X: cam_pos_q[0] <= cfg_data_i[CRD_W-1:0];
        REG_CAM_POS_Y: cam_pos_q[1] <= cfg_data_i[CRD_W-1:0];
        REG_CAM_POS_Z: cam_pos_q[2] <= cfg_data_i[CRD_W-1:0];
        REG_CAM_DIR_X: cam_dir_q[0] <= cfg_data_i[CRD_W-1:0];
        REG_CAM_DIR_Y: cam_dir_q[1] <= cfg_data_i[CRD_W-1:0];
        REG_CAM_DIR_Z: cam_dir_q[2] <= cfg_data_i[CRD_W-1:0];
        REG_HIT_LIMIT: limit_q      <= cfg_data_i[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer. A tested entity walks every step once; the decision cycle
  // waits only when it has a result to hand over and the output is full.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
      step_q  <= STEP_DX;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    step_d    = STEP_DX;
    finish_go = 1'b0;
    unique case (state_q)
      FSM_IDLE: begin
        if (in_acc && (in_i.mode == MODE_ENTITY)) begin
          state_d = (in_i.alive && ent_in_range) ? FSM_RUN : FSM_FINISH;
        end
      end
      FSM_RUN: begin
        if (step_q == STEP_FLUSH) begin
          state_d = FSM_FINISH;
        end else begin
          step_d = nrhp_step_e'(step_q + 4'd1);
        end
      end
      FSM_FINISH: begin
        if (!last_q || slot_free) begin
          finish_go = 1'b1;
          state_d   = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  assign emit = finish_go && last_q;

  // --------------------------------------------------------------------------
  // Entity capture. The camera-to-entity vector is exact in 25 bits.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_acc && (in_i.mode == MODE_ENTITY)) begin
      c_q[0]    <= C_W'(cam_pos_q[0]) - C_W'(in_i.vec_x);
      c_q[1]    <= C_W'(cam_pos_q[1]) - C_W'(in_i.vec_y);
      c_q[2]    <= C_W'(cam_pos_q[2]) - C_W'(in_i.vec_z);
      cur_idx_q <= ent_cnt_q[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      test_q   <= 1'b0;
      last_q   <= 1'b0;
      acc_en_q <= 1'b0;
    end else begin
      if (in_acc && (in_i.mode == MODE_ENTITY)) begin
        test_q <= in_i.alive && ent_in_range;
        last_q <= in_i.last;
      end
      acc_en_q <= (state_q == FSM_RUN);
    end
  end

  // --------------------------------------------------------------------------
  // Shared multiplier. Operands are chosen by the current step; the product
  // is registered and folded into its accumulator in the cycle after.
  // --------------------------------------------------------------------------
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (step_q)
      STEP_DX:  begin op_a = OP_W'(c_q[0]); op_b = OP_W'(cam_dir_q[0]); end
      STEP_DY:  begin op_a = OP_W'(c_q[1]); op_b = OP_W'(cam_dir_q[1]); end
      STEP_DZ:  begin op_a = OP_W'(c_q[2]); op_b = OP_W'(cam_dir_q[2]); end
      STEP_QX:  begin op_a = OP_W'(c_q[0]); op_b = OP_W'(c_q[0]); end
      STEP_QY:  begin op_a = OP_W'(c_q[1]); op_b = OP_W'(c_q[1]); end
      STEP_QZ:  begin op_a = OP_W'(c_q[2]); op_b = OP_W'(c_q[2]); end
      STEP_R0A: begin op_a = OP_W'(c_q[1]); op_b = OP_W'(ray_q[2]); end
      STEP_R0B: begin op_a = OP_W'(c_q[2]); op_b = OP_W'(ray_q[1]); end
      STEP_R1A: begin op_a = OP_W'(c_q[2]); op_b = OP_W'(ray_q[0]); end
      STEP_R1B: begin op_a = OP_W'(c_q[0]); op_b = OP_W'(ray_q[2]); end
      STEP_R2A: begin op_a = OP_W'(c_q[0]); op_b = OP_W'(ray_q[1]); end
      STEP_R2B: begin op_a = OP_W'(c_q[1]); op_b = OP_W'(ray_q[0]); end
      STEP_M0:  begin op_a = $signed({1'b0, mag_q[0]}); op_b = $signed({1'b0, mag_q[0]}); end
      STEP_M1:  begin op_a = $signed({1'b0, mag_q[1]}); op_b = $signed({1'b0, mag_q[1]}); end
      STEP_M2:  begin op_a = $signed({1'b0, mag_q[2]}); op_b = $signed({1'b0, mag_q[2]}); end
      default: ;
    endcase
  end

  assign cm = cross_mag(cr_q);

  always_ff @(posedge clk_i) begin
    prod_q    <= op_a * op_b;
    acc_tag_q <= step_q;
    if (acc_en_q) begin
      unique case (acc_tag_q)
        STEP_DX:  dot_q  <= $signed(prod_q[DOT_W-1:0]);
        STEP_DY,
        STEP_DZ:  dot_q  <= dot_q + $signed(prod_q[DOT_W-1:0]);
        STEP_QX:  dist_q <= prod_q[DIST_W-1:0];
        STEP_QY,
        STEP_QZ:  dist_q <= dist_q + prod_q[DIST_W-1:0];
        STEP_R0A: cr_q   <= $signed(prod_q[CR_W-1:0]);
        STEP_R0B: cr_q   <= cr_q - $signed(prod_q[CR_W-1:0]);
        STEP_R1A: begin
          cr_q     <= $signed(prod_q[CR_W-1:0]);
          mag_q[0] <= cm.mag;
          big_q    <= cm.big;
        end
        STEP_R1B: cr_q <= cr_q - $signed(prod_q[CR_W-1:0]);
        STEP_R2A: begin
          cr_q     <= $signed(prod_q[CR_W-1:0]);
          mag_q[1] <= cm.mag;
          big_q    <= big_q | cm.big;
        end
        STEP_R2B: cr_q <= cr_q - $signed(prod_q[CR_W-1:0]);
        STEP_M0: begin
          mag_q[2] <= cm.mag;
          big_q    <= big_q | cm.big;
          xsq_q    <= prod_q[XSQ_W-1:0];
        end
        STEP_M1,
        STEP_M2:  xsq_q <= xsq_q + prod_q[XSQ_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Decision. An entity in front of the camera whose squared cross product
  // is under the limit is a hit; a strictly nearer hit replaces the best,
  // so on equal distances the earlier entity stays.
  // --------------------------------------------------------------------------
  assign dot_pos  = !dot_q[DOT_W-1] && (dot_q != '0);
  assign hit      = test_q && !dot_pos && !big_q && (xsq_q < XSQ_W'(limit_q));
  assign better   = hit && (!hit_seen_q || (dist_q < best_dist_q));
  assign new_seen = hit_seen_q || hit;
  assign new_idx  = better ? cur_idx_q : best_idx_q;
  assign new_dist = better ? dist_q : best_dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ray_q[0]    <= '0;
      ray_q[1]    <= '0;
      ray_q[2]    <= '0;
      best_dist_q <= '1;
      best_idx_q  <= '0;
      hit_seen_q  <= 1'b0;
      ent_cnt_q   <= '0;
    end else begin
      if (in_acc && (in_i.mode == MODE_RAY)) begin
        // A ray load starts a fresh query.
        ray_q[0]    <= in_i.vec_x;
        ray_q[1]    <= in_i.vec_y;
        ray_q[2]    <= in_i.vec_z;
        best_dist_q <= '1;
        best_idx_q  <= '0;
        hit_seen_q  <= 1'b0;
        ent_cnt_q   <= '0;
      end else if (in_acc && ent_in_range) begin
        ent_cnt_q <= ent_cnt_q + CNT_W'(1);
      end
      if (finish_go) begin
        if (last_q) begin
          // The ray stays, everything else goes back to its reset value.
          best_dist_q <= '1;
          best_idx_q  <= '0;
          hit_seen_q  <= 1'b0;
          ent_cnt_q   <= '0;
        end else begin
          best_dist_q <= new_dist;
          best_idx_q  <= new_idx;
          hit_seen_q  <= new_seen;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result register. Index and distance read as zero when nothing was hit.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_found_q <= new_seen;
      out_idx_q   <= new_seen ? new_idx : '0;
      out_dist_q  <= new_seen ? new_dist : '0;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_miss_is_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_found_q) |-> ((out_idx_q == '0) && (out_dist_q == '0)))
    else $error("miss result carries a non-zero index or distance");

  a_result_from_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past((state_q == FSM_FINISH) && last_q))
    else $error("result beat raised without a finished last entity");

  a_ray_clears_query : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_i.mode == MODE_RAY)) |=> ((ent_cnt_q == '0) && !hit_seen_q))
    else $error("ray load did not clear the query");

  a_run_ends_in_finish : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == FSM_RUN) && (step_q == STEP_FLUSH)) |=> (state_q == FSM_FINISH))
    else $error("sequencer left the last step without deciding");

endmodule
`default_nettype wire

FILE: sim/nearest_ray_hit_picker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest ray hit picker testbench
// Sends ray loads and entity beats, predicts every pick result in its own
// fixed-point model and checks each result beat against the oldest pending
// prediction, under several settings and several patterns of idling.
// ----------------------------------------------------------------------------
module nearest_ray_hit_picker_tb;
  import nrhp_pkg::*;

  // Cycles allowed after the last result for an entity still in the sequencer.
  localparam int unsigned SETTLE_CYCLES  = 40;
  // Cycles without any beat on either channel before the run is abandoned.
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  // Length of the long receiver hold-off.
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned PHASE_ITEMS    = 140;
  localparam longint unsigned MASK50     = (64'd1 << 50) - 64'd1;
  localparam longint ONE                 = 4096;  // 1.0 in Q12.12

  typedef struct packed {
    logic             mode;
    logic [CRD_W-1:0] x;
    logic [CRD_W-1:0] y;
    logic [CRD_W-1:0] z;
    logic             alive;
    logic             last;
  } beat_t;

  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  index;
    logic [DIST_W-1:0] dist_sq;
  } pick_t;

  typedef struct packed {
    logic [2:0][CRD_W-1:0] pos;
    logic [2:0][CRD_W-1:0] dir;
    logic [LIM_W-1:0]      limit;
  } setup_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  nrhp_in_if  in_if ();
  nrhp_out_if out_if ();

  nearest_ray_hit_picker dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Model state: the settings as the block holds them, the stored ray and
  // the running best of the current query.
  longint          cam_pos [3];
  longint          cam_dir [3];
  longint unsigned hit_limit;
  longint          ray [3];
  longint unsigned near_dist;
  int unsigned     near_idx;
  bit              near_hit;
  int unsigned     ent_count;

  // Picks predicted but not yet seen on the result channel, oldest first.
  pick_t       pick_q [$];
  int unsigned err_count = 0;

  // Idling percentages. The sender's is only used by the main process; the
  // receiver's is read by the receiver process.
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  // Each increment asks the receiver process for one long hold-off.
  int unsigned hold_req = 0;

  function automatic longint sx24(logic [CRD_W-1:0] v);
    return longint'($signed(v));
  endfunction

  function automatic void clear_query();
    near_dist = MASK50;
    near_idx  = 0;
    near_hit  = 1'b0;
    ent_count = 0;
  endfunction

  // Tests one live entity at the current index and updates the running best.
  function automatic void try_entity(longint px, longint py, longint pz);
    longint          c [3];
    longint          cr [3];
    longint          dot;
    longint unsigned m;
    longint unsigned xsq;
    longint unsigned d_sq;
    int              i;
    c[0] = cam_pos[0] - px;
    c[1] = cam_pos[1] - py;
    c[2] = cam_pos[2] - pz;
    dot = c[0] * cam_dir[0] + c[1] * cam_dir[1] + c[2] * cam_dir[2];
    // Behind the camera: not a candidate at all.
    if (dot > 0) return;
    cr[0] = c[1] * ray[2] - c[2] * ray[1];
    cr[1] = c[2] * ray[0] - c[0] * ray[2];
    cr[2] = c[0] * ray[1] - c[1] * ray[0];
    xsq = 0;
    for (i = 0; i < 3; i++) begin
      // Magnitude truncated to twelve fraction bits; anything this large
      // squares past every possible limit.
      m = longint'(cr[i] < 0 ? -cr[i] : cr[i]) >> 12;
      if (m >= (64'd1 << 25)) return;
      xsq += m * m;
    end
    if (!(xsq < hit_limit)) return;
    d_sq = longint'(c[0] * c[0] + c[1] * c[1] + c[2] * c[2]) & MASK50;
    // Strictly smaller only, so the earliest of equal distances stays.
    if (!near_hit || d_sq < near_dist) begin
      near_dist = d_sq;
      near_idx  = ent_count;
      near_hit  = 1'b1;
    end
  endfunction

  // Advances the model by one accepted beat and queues any pick it causes.
  function automatic void predict_pick(beat_t b);
    pick_t p;
    if (b.mode == MODE_RAY) begin
      ray[0] = sx24(b.x);
      ray[1] = sx24(b.y);
      ray[2] = sx24(b.z);
      clear_query();
      return;
    end
    // Past the entity limit the beat only counts for its last flag.
    if (ent_count < MAX_ENTITIES) begin
      if (b.alive) try_entity(sx24(b.x), sx24(b.y), sx24(b.z));
      ent_count++;
    end
    if (b.last) begin
      p.found   = near_hit;
      p.index   = near_hit ? IDX_W'(near_idx) : '0;
      p.dist_sq = near_hit ? DIST_W'(near_dist) : '0;
      pick_q.push_back(p);
      clear_query();
    end
  endfunction

  function automatic beat_t make_beat(logic mode, longint x, longint y, longint z,
                                      logic alive, logic last);
    beat_t b;
    b.mode  = mode;
    b.x     = CRD_W'(x);
    b.y     = CRD_W'(y);
    b.z     = CRD_W'(z);
    b.alive = alive;
    b.last  = last;
    return b;
  endfunction

  // A beat with every field random, the mode included.
  function automatic beat_t noise_beat();
    beat_t b;
    b.mode  = 1'($urandom_range(1));
    b.x     = CRD_W'($urandom());
    b.y     = CRD_W'($urandom());
    b.z     = CRD_W'($urandom());
    b.alive = 1'($urandom_range(1));
    b.last  = 1'($urandom_range(1));
    return b;
  endfunction

  // A unit ray in Q12.12, turned to face the same way as the camera
  // direction so that entities along it are not behind the camera.
  function automatic void make_ray(output longint r [3]);
    real    v [3];
    real    len;
    longint d;
    int     i;
    do begin
      for (i = 0; i < 3; i++) v[i] = real'($urandom_range(8192)) - 4096.0;
      len = $sqrt(v[0] * v[0] + v[1] * v[1] + v[2] * v[2]);
    end while (len < 64.0);
    d = 0;
    for (i = 0; i < 3; i++) begin
      r[i] = longint'($rtoi(4096.0 * v[i] / len));
      d += r[i] * cam_dir[i];
    end
    if (d < 0) begin
      for (i = 0; i < 3; i++) r[i] = -r[i];
    end
  endfunction

  // An entity up to 600 units along the ray from the camera, pushed off the
  // line by up to half a unit per axis so that it lands on either side of
  // the default hit radius.
  function automatic beat_t entity_on_ray(longint r [3], logic alive, logic last);
    longint t;
    longint c;
    longint p [3];
    int     i;
    t = longint'($urandom_range(600 * 4096));
    for (i = 0; i < 3; i++) begin
      c    = -(t * r[i]) / ONE + longint'($urandom_range(4096)) - 2048;
      p[i] = cam_pos[i] - c;
    end
    return make_beat(MODE_ENTITY, p[0], p[1], p[2], alive, last);
  endfunction

  function automatic setup_t random_setup(bit full_dir, logic [LIM_W-1:0] limit);
    setup_t s;
    longint r [3];
    int     i;
    make_ray(r);
    for (i = 0; i < 3; i++) begin
      s.pos[i] = CRD_W'(longint'($urandom_range(2 * 1000 * 4096)) - 1000 * 4096);
      s.dir[i] = full_dir ? CRD_W'($urandom()) : CRD_W'(r[i]);
    end
    s.limit = limit;
    return s;
  endfunction

  // Offers one beat, possibly after some idle cycles, and waits for the
  // handshake. Entered and left at a rising edge.
  task automatic send_beat(beat_t b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.mode  <= b.mode;
    in_if.vec_x <= b.x;
    in_if.vec_y <= b.y;
    in_if.vec_z <= b.z;
    in_if.alive <= b.alive;
    in_if.last  <= b.last;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
    predict_pick(b);
  endtask

  // Stops offering, waits for every pending pick and then for an entity
  // that may still be in the sequencer without a result.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pick_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Leaves the write enable high; the caller lowers it after the last write
  // so that it is never lowered and raised in one step.
  task automatic write_reg(nrhp_reg_e r, logic [CFG_DATA_W-1:0] d);
    cfg_we   <= 1'b1;
    cfg_idx  <= r;
    cfg_data <= d;
    @(posedge clk_i);
    case (r)
      REG_CAM_POS_X: cam_pos[0] = sx24(d[CRD_W-1:0]);
      REG_CAM_POS_Y: cam_pos[1] = sx24(d[CRD_W-1:0]);
      REG_CAM_POS_Z: cam_pos[2] = sx24(d[CRD_W-1:0]);
      REG_CAM_DIR_X: cam_dir[0] = sx24(d[CRD_W-1:0]);
      REG_CAM_DIR_Y: cam_dir[1] = sx24(d[CRD_W-1:0]);
      REG_CAM_DIR_Z: cam_dir[2] = sx24(d[CRD_W-1:0]);
      REG_HIT_LIMIT: hit_limit  = d;
      default: ;
    endcase
  endtask

  task automatic apply_setup(setup_t s);
    wait_idle();
    write_reg(REG_CAM_POS_X, CFG_DATA_W'(s.pos[0]));
    write_reg(REG_CAM_POS_Y, CFG_DATA_W'(s.pos[1]));
    write_reg(REG_CAM_POS_Z, CFG_DATA_W'(s.pos[2]));
    write_reg(REG_CAM_DIR_X, CFG_DATA_W'(s.dir[0]));
    write_reg(REG_CAM_DIR_Y, CFG_DATA_W'(s.dir[1]));
    write_reg(REG_CAM_DIR_Z, CFG_DATA_W'(s.dir[2]));
    write_reg(REG_HIT_LIMIT, CFG_DATA_W'(s.limit));
    cfg_we <= 1'b0;
  endtask

  task automatic set_idling(int unsigned tx, int unsigned rx);
    tx_idle_pct  = tx;
    rx_stall_pct <= rx;
  endtask

  // Out of reset, before any ray: the stored ray is zero, so every live
  // entity in front of the camera is a hit. The last query is all-miss.
  task automatic test_before_ray_load();
    set_idling(0, 0);
    send_beat(make_beat(MODE_ENTITY, 0, 0, -ONE, 1'b1, 1'b0));
    send_beat(make_beat(MODE_ENTITY, 0, 0, ONE, 1'b1, 1'b0));
    send_beat(make_beat(MODE_ENTITY, 0, 0, -ONE / 2, 1'b1, 1'b1));
    send_beat(make_beat(MODE_ENTITY, 5, -7, -ONE, 1'b0, 1'b1));
  endtask

  // Extreme coordinates and settings: cross products too large to square,
  // entities on the camera itself, equal distances and a zero hit limit.
  task automatic test_field_extremes();
    setup_t s;
    s.pos   = {3{24'h800000}};
    s.dir   = {3{24'h7FFFFF}};
    s.limit = LIM_W'(MASK50);
    apply_setup(s);
    // A ray load with alive and last set must still produce nothing.
    send_beat(make_beat(MODE_RAY, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 1'b1, 1'b1));
    send_beat(make_beat(MODE_ENTITY, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1, 1'b0));
    send_beat(make_beat(MODE_ENTITY, 24'h800000, 24'h800000, 24'h800000, 1'b1, 1'b0));
    send_beat(make_beat(MODE_ENTITY, 24'h800000, 24'h800000, 24'h800000, 1'b1, 1'b0));
    send_beat(make_beat(MODE_ENTITY, 24'h7FFFFF, 24'h800000, 24'h800000, 1'b0, 1'b1));
    s.pos   = '0;
    s.dir   = '0;
    s.limit = '0;
    apply_setup(s);
    send_beat(make_beat(MODE_ENTITY, 0, 0, 0, 1'b1, 1'b1));
    s.pos   = {3{24'h7FFFFF}};
    s.dir   = {3{24'h800000}};
    s.limit = LIMIT_RST;
    apply_setup(s);
    send_beat(make_beat(MODE_ENTITY, 24'h800000, 24'h800000, 24'h800000, 1'b1, 1'b0));
    send_beat(make_beat(MODE_ENTITY, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1, 1'b1));
  endtask

  // Ties, a ray load in the middle of a query, a query reusing the kept
  // ray and an unnormalised ray.
  task automatic test_ties_and_restart();
    setup_t s;
    s.pos   = '0;
    s.dir   = {24'd0, 24'd0, CRD_W'(ONE)};
    s.limit = LIMIT_RST;
    apply_setup(s);
    send_beat(make_beat(MODE_RAY, ONE, 0, 0, 1'b0, 1'b0));
    send_beat(make_beat(MODE_ENTITY, 5 * ONE, 100, 0, 1'b1, 1'b0));
    send_beat(make_beat(MODE_ENTITY, 5 * ONE, 100, 0, 1'b1, 1'b0));
    send_beat(make_beat(MODE_RAY, ONE, 0, 0, 1'b0, 1'b1));
    send_beat(make_beat(MODE_ENTITY, 10 * ONE, 0, 0, 1'b1, 1'b0));
    send_beat(make_beat(MODE_ENTITY, 2 * ONE, 0, 0, 1'b1, 1'b1));
    send_beat(make_beat(MODE_ENTITY, 3 * ONE, 0, 0, 1'b1, 1'b1));
    send_beat(make_beat(MODE_RAY, 4 * ONE, 0, 0, 1'b0, 1'b0));
    send_beat(make_beat(MODE_ENTITY, 5 * ONE, 50, 0, 1'b1, 1'b1));
  endtask

  // One query longer than the entity limit; live entities past the limit
  // are nearer but must not be taken.
  task automatic test_entity_limit();
    setup_t s;
    int     i;
    bit     live;
    s.pos   = '0;
    s.dir   = {DIR_Z_RST, 24'd0, 24'd0};
    s.limit = LIMIT_RST;
    apply_setup(s);
    set_idling(0, 0);
    send_beat(make_beat(MODE_RAY, 0, 0, -ONE, 1'b0, 1'b0));
    for (i = 0; i < MAX_ENTITIES + 6; i++) begin
      live = (i == 1000) || (i == MAX_ENTITIES - 1) || (i == MAX_ENTITIES) ||
             (i == MAX_ENTITIES + 2);
      if (live) begin
        send_beat(make_beat(MODE_ENTITY, 0, 0, (longint'(i) - 1100) * ONE, 1'b1,
                            i == MAX_ENTITIES + 5));
      end else begin
        send_beat(make_beat(MODE_ENTITY, longint'($urandom()), longint'($urandom()),
                            longint'($urandom()), 1'b0, i == MAX_ENTITIES + 5));
      end
    end
  endtask

  // The receiver holds off for a long stretch while short queries keep
  // coming, so that the output register fills and the input stalls.
  task automatic test_result_backpressure();
    longint r [3];
    int     i;
    set_idling(0, 0);
    hold_req <= hold_req + 1;
    make_ray(r);
    send_beat(make_beat(MODE_RAY, r[0], r[1], r[2], 1'b0, 1'b0));
    for (i = 0; i < 24; i++) send_beat(entity_on_ray(r, 1'b1, 1'b1));
  endtask

  // Mostly well-formed queries with random content: a ray load followed by
  // a few entities near the ray, the last one flagged. Some queries are broken
  // off by the next ray load, and noise beats come between and within queries.
  task automatic run_random_phase(setup_t s, int unsigned tx, int unsigned rx,
                                  bit pause_midway);
    longint      r [3];
    beat_t       b;
    beat_t       prev;
    int unsigned sent;
    int unsigned n;
    int unsigned k;
    int unsigned roll;
    bit          broken;
    bit          paused;
    bit          have_prev;
    apply_setup(s);
    set_idling(tx, rx);
    sent   = 0;
    paused = 1'b0;
    while (sent < PHASE_ITEMS) begin
      if ($urandom_range(99) < 10) begin
        send_beat(noise_beat());
        sent++;
      end else begin
        if ($urandom_range(9) == 0) begin
          for (k = 0; k < 3; k++) r[k] = sx24(CRD_W'($urandom()));
        end else begin
          make_ray(r);
        end
        send_beat(make_beat(MODE_RAY, r[0], r[1], r[2], 1'($urandom_range(1)),
                            1'($urandom_range(1))));
        n         = ($urandom_range(29) == 0) ? $urandom_range(40, 10) : $urandom_range(8, 1);
        broken    = ($urandom_range(19) == 0);
        have_prev = 1'b0;
        for (k = 0; k < n; k++) begin
          roll = $urandom_range(99);
          if (roll < 10 && have_prev) begin
            // Same position again: an exact tie with an earlier entity.
            b = prev;
          end else if (roll < 20) begin
            b      = noise_beat();
            b.mode = MODE_ENTITY;
          end else begin
            b = entity_on_ray(r, 1'b1, 1'b0);
          end
          b.alive = ($urandom_range(99) < 85);
          b.last  = (k == n - 1) && !broken;
          send_beat(b);
          prev      = b;
          have_prev = 1'b1;
          sent++;
        end
        sent++;
      end
      // Once per phase where asked, the sender pauses until the result
      // channel has caught up completely.
      if (pause_midway && !paused && sent >= PHASE_ITEMS / 2) begin
        wait_idle();
        paused = 1'b1;
      end
    end
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested.
  initial begin
    int unsigned hold_seen;
    int unsigned hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Result checker: every accepted result beat against the oldest pick.
  always @(posedge clk_i) begin
    pick_t e;
    if (out_if.valid && out_if.ready) begin
      if (pick_q.size() == 0) begin
        $error("result beat arrived with no pick pending");
        err_count++;
      end else begin
        e = pick_q.pop_front();
        if (out_if.found !== e.found) begin
          $error("found: expected %0d, actual %0d", e.found, out_if.found);
          err_count++;
        end
        if (out_if.best_index !== e.index) begin
          $error("best_index: expected %0d, actual %0d", e.index, out_if.best_index);
          err_count++;
        end
        if (out_if.best_dist_sq !== e.dist_sq) begin
          $error("best_dist_sq: expected %0d, actual %0d", e.dist_sq, out_if.best_dist_sq);
          err_count++;
        end
      end
    end
  end

  // Watchdog: too long without a beat on either channel means a hang.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_ni      <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_idx     <= '0;
    cfg_data    <= '0;
    in_if.valid <= 1'b0;
    in_if.mode  <= MODE_RAY;
    in_if.vec_x <= '0;
    in_if.vec_y <= '0;
    in_if.vec_z <= '0;
    in_if.alive <= 1'b0;
    in_if.last  <= 1'b0;
    cam_pos     = '{0, 0, 0};
    cam_dir     = '{0, 0, 0};
    cam_dir[2]  = sx24(DIR_Z_RST);
    hit_limit   = LIMIT_RST;
    ray         = '{0, 0, 0};
    clear_query();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_before_ray_load();
    test_field_extremes();
    test_ties_and_restart();
    test_entity_limit();

    run_random_phase({72'd0, DIR_Z_RST, 24'd0, 24'd0, LIMIT_RST}, 0, 0, 1'b0);
    test_result_backpressure();
    run_random_phase(random_setup(1'b0, LIM_W'($urandom_range(1 << 26))), 72, 0, 1'b1);
    run_random_phase(random_setup(1'b1, LIM_W'($urandom_range(1 << 24))), 0, 72, 1'b0);
    run_random_phase(random_setup(1'b0, LIM_W'(MASK50)), 13, 13, 1'b0);

    wait_idle();
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/nrhp_pkg.sv
rtl/core/nrhp_if.sv
rtl/core/nearest_ray_hit_picker.sv
sim/nearest_ray_hit_picker_tb.sv
